[rtl/pps_pkg.sv]
// Shared types and constants for the procedural pattern shader.
// No dependencies; the channel interfaces and the core import this package.
`default_nettype none

package pps_pkg;

   localparam int CoordWidth     = 32;
   localparam int ColorPortWidth = 16;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 16;
   localparam int ModeBits       = 3;

   typedef enum logic [ModeBits-1:0] {
      MODE_STRIPE   = 3'd0,
      MODE_GRADIENT = 3'd1,
      MODE_RING     = 3'd2,
      MODE_CHECKER  = 3'd3,
      MODE_RADIAL   = 3'd4,
      MODE_SOLID    = 3'd5
   } pattern_mode_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MODE    = 3'd0,
      CSR_A_RED   = 3'd1,
      CSR_A_GREEN = 3'd2,
      CSR_A_BLUE  = 3'd3,
      CSR_B_RED   = 3'd4,
      CSR_B_GREEN = 3'd5,
      CSR_B_BLUE  = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

[rtl/pps_req_if.sv]
// Point channel: one pattern-space point per beat.
// Depends on pps_pkg for the coordinate width.
`default_nettype none

interface pps_req_if;
   import pps_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [CoordWidth-1:0] x_coord;
   logic signed [CoordWidth-1:0] y_coord;
   logic signed [CoordWidth-1:0] z_coord;

   modport source (output valid, output x_coord, output y_coord, output z_coord,
                   input ready);
   modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                   output ready);
endinterface

`default_nettype wire

[rtl/pps_rsp_if.sv]
// Color channel: one RGB color per beat.
// Depends on pps_pkg for the color port width.
`default_nettype none

interface pps_rsp_if;
   import pps_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ColorPortWidth-1:0] red_out;
   logic [ColorPortWidth-1:0] green_out;
   logic [ColorPortWidth-1:0] blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

`default_nettype wire

[rtl/pps_csr_if.sv]
// Register write channel: one register index and its data per beat.
// Depends on pps_pkg for the index and data widths.
`default_nettype none

interface pps_csr_if;
   import pps_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/procedural_pattern_shader_core.sv]
// Procedural pattern shader: stripe, gradient, ring, checkers, radial gradient, solid.
// Depends on pps_pkg and the channel interfaces pps_req_if, pps_rsp_if, pps_csr_if.
//
//   Channel   Side   Beat carries
//   req_if    sink   x_coord, y_coord, z_coord (signed fixed point)
//   rsp_if    source red_out, green_out, blue_out (unsigned Q4.12)
//   csr_if    sink   index, data (register write, always ready)
//
// One point enters per cycle while the output beat is not held; its color leaves from the output stage.
// The pipe depth is set by the radius square root, which resolves one result bit per stage.
// Reset clears the registers to their documented values and empties the pipe.
// When the output beat is held, the whole pipe holds; nothing is dropped or repeated.
`default_nettype none

module procedural_pattern_shader_core #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int COLOR_WIDTH     = 16
) (
   input  wire        clock,
   input  wire        reset,
   pps_req_if.sink    req_if,
   pps_rsp_if.source  rsp_if,
   pps_csr_if.sink    csr_if
);
   import pps_pkg::*;

   localparam int FracBits   = COORD_FRAC_BITS;
   localparam int ColorBits  = (COLOR_WIDTH < ColorPortWidth) ? COLOR_WIDTH : ColorPortWidth;
   localparam int SquareBits = 2 * CoordWidth;
   localparam int SqrtSteps  = CoordWidth;
   localparam int ProdBits   = ColorBits + FracBits + 1;
   localparam int SideBits   = FracBits + 2;
   // Stage map: 0 entry, 1 magnitude, 2 squares, 3..3+SqrtSteps root, then blend, output.
   localparam int RootFirst  = 3;
   localparam int RootLast   = RootFirst + SqrtSteps;
   localparam int BlendStage = RootLast + 1;
   localparam int LastStage  = BlendStage + 1;

   // ---------------- configuration registers ----------------
   pattern_mode_type     mode_ff;
   logic [ColorBits-1:0] color_a_ff [0:2];
   logic [ColorBits-1:0] color_b_ff [0:2];

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_STRIPE;
         for (int c = 0; c < 3; c++) begin
            color_a_ff[c] <= ColorBits'(4096);
            color_b_ff[c] <= '0;
         end
      end else if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_MODE:    mode_ff       <= pattern_mode_type'(csr_if.data[ModeBits-1:0]);
            CSR_A_RED:   color_a_ff[0] <= csr_if.data[ColorBits-1:0];
            CSR_A_GREEN: color_a_ff[1] <= csr_if.data[ColorBits-1:0];
            CSR_A_BLUE:  color_a_ff[2] <= csr_if.data[ColorBits-1:0];
            CSR_B_RED:   color_b_ff[0] <= csr_if.data[ColorBits-1:0];
            CSR_B_GREEN: color_b_ff[1] <= csr_if.data[ColorBits-1:0];
            CSR_B_BLUE:  color_b_ff[2] <= csr_if.data[ColorBits-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic valid_ff [0:LastStage];
   logic advance;

   // Every stage moves together; it stops only while the output beat is held.
   assign advance      = !valid_ff[LastStage] || rsp_if.ready;
   assign req_if.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LastStage; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_if.valid;
         for (int s = 1; s <= LastStage; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   // ---------------- stage 0: capture ----------------
   logic [CoordWidth-1:0] x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= req_if.x_coord;
         y_ff <= req_if.y_coord;
         z_ff <= req_if.z_coord;
      end
   end

   // ---------------- stage 1: magnitudes and parities ----------------
   // Side data (x fraction, checker parity, stripe parity) rides along to the blend.
   logic [SideBits-1:0]   side_ff [1:RootLast];
   logic [SideBits-1:0]   side_in;
   logic [CoordWidth-1:0] abs_x_ff, abs_z_ff;
   logic [CoordWidth-1:0] abs_x_in, abs_z_in;

   always_comb begin
      // The most negative value maps to its own bit pattern, which is the correct magnitude.
      abs_x_in = x_ff[CoordWidth-1] ? (~x_ff + 1'b1) : x_ff;
      abs_z_in = z_ff[CoordWidth-1] ? (~z_ff + 1'b1) : z_ff;
      side_in  = {x_ff[FracBits-1:0],
                  x_ff[FracBits] ^ y_ff[FracBits] ^ z_ff[FracBits],
                  x_ff[FracBits]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abs_x_ff   <= abs_x_in;
         abs_z_ff   <= abs_z_in;
         side_ff[1] <= side_in;
         for (int s = 2; s <= RootLast; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // ---------------- stage 2: squares ----------------
   logic [SquareBits-1:0] sq_x_ff, sq_z_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_x_ff <= SquareBits'(abs_x_ff) * SquareBits'(abs_x_ff);
         sq_z_ff <= SquareBits'(abs_z_ff) * SquareBits'(abs_z_ff);
      end
   end

   // ---------------- root stages: one result bit per stage ----------------
   logic [SquareBits-1:0] rem_ff  [0:SqrtSteps];
   logic [SquareBits-1:0] root_ff [0:SqrtSteps];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= sq_x_ff + sq_z_ff;
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_root
      localparam logic [SquareBits-1:0] TrialBit =
         SquareBits'(1) << (SquareBits - 2 - 2 * k);
      logic [SquareBits-1:0] trial;
      logic [SquareBits-1:0] rem_in, root_in;

      always_comb begin
         trial = root_ff[k] + TrialBit;
         if (rem_ff[k] >= trial) begin
            rem_in  = rem_ff[k] - trial;
            root_in = (root_ff[k] >> 1) + TrialBit;
         end else begin
            rem_in  = rem_ff[k];
            root_in = root_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
         end
      end
   end

   // ---------------- blend stage: pick the fraction and form the weighted products ----------------
   logic [CoordWidth-1:0] radius;
   logic [SideBits-1:0]   side_last;
   logic                  use_b_in, gradient_in;
   logic [FracBits-1:0]   frac_in;
   logic [FracBits:0]     weight_a;
   logic [ProdBits-1:0]   prod_a_in [0:2];
   logic [ProdBits-1:0]   prod_b_in [0:2];
   logic [ProdBits-1:0]   prod_a_ff [0:2];
   logic [ProdBits-1:0]   prod_b_ff [0:2];
   logic                  use_b_ff, gradient_ff;

   assign radius    = root_ff[SqrtSteps][CoordWidth-1:0];
   assign side_last = side_ff[RootLast];

   always_comb begin
      use_b_in    = 1'b0;
      gradient_in = 1'b0;
      frac_in     = '0;
      case (mode_ff)
         MODE_STRIPE:   use_b_in = side_last[0];
         MODE_GRADIENT: begin
            gradient_in = 1'b1;
            frac_in     = side_last[SideBits-1:2];
         end
         MODE_RING:     use_b_in = radius[FracBits];
         MODE_CHECKER:  use_b_in = side_last[1];
         MODE_RADIAL: begin
            gradient_in = 1'b1;
            frac_in     = radius[FracBits-1:0];
         end
         default: begin
         end
      endcase
      weight_a = {1'b1, {FracBits{1'b0}}} - {1'b0, frac_in};
      for (int c = 0; c < 3; c++) begin
         prod_a_in[c] = ProdBits'(color_a_ff[c]) * ProdBits'(weight_a);
         prod_b_in[c] = ProdBits'(color_b_ff[c]) * ProdBits'(frac_in);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         use_b_ff    <= use_b_in;
         gradient_ff <= gradient_in;
         for (int c = 0; c < 3; c++) begin
            prod_a_ff[c] <= prod_a_in[c];
            prod_b_ff[c] <= prod_b_in[c];
         end
      end
   end

   // ---------------- output stage ----------------
   // The blended sum always lies between the two colors, so it fits the color width.
   logic [ProdBits-1:0]  blend_sum [0:2];
   logic [ColorBits-1:0] color_in  [0:2];
   logic [ColorBits-1:0] color_ff  [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         blend_sum[c] = prod_a_ff[c] + prod_b_ff[c];
         if (gradient_ff) begin
            color_in[c] = blend_sum[c][FracBits +: ColorBits];
         end else if (use_b_ff) begin
            color_in[c] = color_b_ff[c];
         end else begin
            color_in[c] = color_a_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) color_ff[c] <= color_in[c];
      end
   end

   assign rsp_if.valid     = valid_ff[LastStage];
   assign rsp_if.red_out   = ColorPortWidth'(color_ff[0]);
   assign rsp_if.green_out = ColorPortWidth'(color_ff[1]);
   assign rsp_if.blue_out  = ColorPortWidth'(color_ff[2]);

endmodule

`default_nettype wire

[dv/procedural_pattern_shader_core_tb.sv]
// Self-checking testbench for procedural_pattern_shader_core: directed probe points, then
// randomized register settings and points checked against a behavioral color predictor.
// Depends on pps_pkg, the channel interfaces pps_req_if, pps_rsp_if, pps_csr_if and the core.
`default_nettype none

module procedural_pattern_shader_core_tb;
   import pps_pkg::*;

   localparam int FracBits       = 16;
   localparam int ResetCycles    = 7;
   localparam int SettleCycles   = 45;
   localparam int HoldCycles     = 300;
   localparam int HoldPoints     = 120;
   localparam int NumPhases      = 16;
   localparam int PointsPerPhase = 100;
   localparam int WatchdogLimit  = 2000;
   localparam int NumProbes      = 22;

   localparam logic [63:0] FracOne = 64'd1 << FracBits;

   // Codes beyond the documented ones: two spare modes and one spare register index.
   localparam logic [ModeBits-1:0]      ModeSpareLow  = 3'd6;
   localparam logic [ModeBits-1:0]      ModeSpareHigh = 3'd7;
   localparam logic [CsrIndexWidth-1:0] CsrSpare      = 3'd7;

   typedef struct packed {
      logic [ColorPortWidth-1:0] red;
      logic [ColorPortWidth-1:0] green;
      logic [ColorPortWidth-1:0] blue;
   } rgb_color_type;

   typedef struct packed {
      logic [ModeBits-1:0]   mode;
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
      logic [CoordWidth-1:0] z;
      logic                  literal;
      rgb_color_type         color;
   } probe_row_type;

   localparam rgb_color_type UnitA = '{16'h1000, 16'h1000, 16'h1000};
   localparam rgb_color_type HalfA = '{16'h0800, 16'h0800, 16'h0800};
   localparam rgb_color_type Black = '{16'h0000, 16'h0000, 16'h0000};

   // Colors are still at their reset values (a is 1.0, b is 0) while these run.
   localparam probe_row_type Probes [NumProbes] = '{
      '{MODE_STRIPE,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, UnitA},
      '{MODE_STRIPE,   32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, Black},
      '{MODE_STRIPE,   32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, Black},
      '{MODE_STRIPE,   32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, UnitA},
      '{MODE_STRIPE,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, Black},
      '{MODE_STRIPE,   32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1, UnitA},
      '{MODE_GRADIENT, 32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 1'b1, HalfA},
      '{MODE_GRADIENT, 32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, Black},
      '{MODE_GRADIENT, 32'h1234_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, UnitA},
      '{MODE_RING,     32'h0003_0000, 32'h0000_0000, 32'h0004_0000, 1'b1, Black},
      '{MODE_RING,     32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, Black},
      '{MODE_RING,     32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, Black},
      '{MODE_CHECKER,  32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, Black},
      '{MODE_CHECKER,  32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, UnitA},
      '{MODE_CHECKER,  32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0, Black},
      '{MODE_RADIAL,   32'h0003_0000, 32'h0000_0000, 32'h0004_0000, 1'b1, UnitA},
      '{MODE_RADIAL,   32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 1'b1, HalfA},
      '{MODE_RADIAL,   32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, Black},
      '{MODE_RADIAL,   32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, Black},
      '{MODE_SOLID,    32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, UnitA},
      '{ModeSpareLow,  32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, UnitA},
      '{ModeSpareHigh, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0001_0000, 1'b1, UnitA}
   };

   logic clock = 1'b0;
   logic reset;

   pps_req_if req_if ();
   pps_rsp_if rsp_if ();
   pps_csr_if csr_if ();

   procedural_pattern_shader_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the register file, updated on each accepted register beat.
   logic [ModeBits-1:0]       mode_reg = MODE_STRIPE;
   logic [ColorPortWidth-1:0] color_a [3] = '{16'h1000, 16'h1000, 16'h1000};
   logic [ColorPortWidth-1:0] color_b [3] = '{16'h0000, 16'h0000, 16'h0000};

   rgb_color_type pending_colors [$];

   int  send_idle_pct  = 0;
   int  stall_pct      = 0;
   bit  hold_phase     = 1'b0;
   int  held_cycles    = 0;
   int  quiet_cycles   = 0;
   int  mismatches     = 0;
   int  points_sent    = 0;
   int  colors_checked = 0;
   int  settings_count = 0;

   function automatic rgb_color_type shade_point(input logic signed [CoordWidth-1:0] x, y, z);
      longint                    sx, sz;
      logic [63:0]               mag_x, mag_z, dist_sq, radius, trial;
      logic [FracBits-1:0]       frac;
      logic                      pick_b, blended;
      logic [ColorPortWidth-1:0] chan [3];
      sx = x;
      sz = z;
      mag_x = (sx < 0) ? -sx : sx;
      mag_z = (sz < 0) ? -sz : sz;
      dist_sq = mag_x * mag_x + mag_z * mag_z;
      // Integer square root by setting result bits from the top while the square still fits.
      radius = '0;
      for (int k = 31; k >= 0; k--) begin
         trial = radius | (64'd1 << k);
         if (trial * trial <= dist_sq) radius = trial;
      end
      pick_b  = 1'b0;
      blended = 1'b0;
      frac    = '0;
      case (mode_reg)
         MODE_STRIPE:   pick_b = x[FracBits];
         MODE_GRADIENT: begin
            blended = 1'b1;
            frac    = x[FracBits-1:0];
         end
         MODE_RING:     pick_b = radius[FracBits];
         MODE_CHECKER:  pick_b = x[FracBits] ^ y[FracBits] ^ z[FracBits];
         MODE_RADIAL:   begin
            blended = 1'b1;
            frac    = radius[FracBits-1:0];
         end
         default:       pick_b = 1'b0;
      endcase
      for (int i = 0; i < 3; i++) begin
         if (blended)
            chan[i] = 16'((64'(color_a[i]) * (FracOne - 64'(frac)) +
                           64'(color_b[i]) * 64'(frac)) >> FracBits);
         else
            chan[i] = pick_b ? color_b[i] : color_a[i];
      end
      return '{chan[0], chan[1], chan[2]};
   endfunction

   function automatic logic signed [CoordWidth-1:0] random_coord();
      logic signed [CoordWidth-1:0] c;
      case ($urandom_range(9))
         0, 1, 2: c = $urandom;
         3, 4, 5, 6, 7: c = 32'($urandom_range(1048575)) - 32'd524288;
         default: c = {16'($signed(4'($urandom))), ($urandom_range(1) ? 16'hFFFF : 16'h0000)};
      endcase
      return c;
   endfunction

   function automatic void check_channel(input string name, input logic [ColorPortWidth-1:0] want,
                                         input logic [ColorPortWidth-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endfunction

   task automatic send_point(input logic signed [CoordWidth-1:0] x, y, z,
                             input logic literal, input rgb_color_type known);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.x_coord <= x;
      req_if.y_coord <= y;
      req_if.z_coord <= z;
      do @(posedge clock); while (!req_if.ready);
      pending_colors.push_back(literal ? known : shade_point(x, y, z));
      points_sent++;
   endtask

   // Always waits on the clock before returning, so a following beat never re-raises valid in this step.
   task automatic drain_colors();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_colors.size() != 0);
   endtask

   task automatic set_register(input logic [CsrIndexWidth-1:0] index,
                               input logic [CsrDataWidth-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (index)
         CSR_MODE:                            mode_reg = data[ModeBits-1:0];
         CSR_A_RED, CSR_A_GREEN, CSR_A_BLUE:  color_a[2'(index - CSR_A_RED)] = data;
         CSR_B_RED, CSR_B_GREEN, CSR_B_BLUE:  color_b[2'(index - CSR_B_RED)] = data;
         default: ;
      endcase
   endtask

   // Receiver: random stalls, or one long hold-off at the start of the hold phase.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_phase && held_cycles < HoldCycles) begin
            held_cycles++;
            rsp_if.ready <= 1'b0;
         end else begin
            if (!hold_phase) held_cycles = 0;
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rgb_color_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_colors.size() == 0) begin
            mismatches++;
            $display("%0t: color %h %h %h arrived with none expected", $time,
                     rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out);
         end else begin
            want = pending_colors.pop_front();
            check_channel("red", want.red, rsp_if.red_out);
            check_channel("green", want.green, rsp_if.green_out);
            check_channel("blue", want.blue, rsp_if.blue_out);
            colors_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CsrDataWidth-1:0] palette [6];
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.x_coord = '0;
      req_if.y_coord = '0;
      req_if.z_coord = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_MODE;
      csr_if.data    = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      foreach (Probes[i]) begin
         if (Probes[i].mode != mode_reg) begin
            drain_colors();
            set_register(CSR_MODE, 16'(Probes[i].mode));
            csr_if.valid <= 1'b0;
            settings_count++;
         end
         send_point(Probes[i].x, Probes[i].y, Probes[i].z, Probes[i].literal, Probes[i].color);
      end

      // Hold phase: the receiver holds off while points keep coming, so the pipe backs up.
      drain_colors();
      send_idle_pct = 0;
      stall_pct  <= 0;
      hold_phase <= 1'b1;
      repeat (HoldPoints) send_point(random_coord(), random_coord(), random_coord(), 1'b0, Black);
      drain_colors();
      hold_phase <= 1'b0;

      for (int p = 0; p < NumPhases; p++) begin
         case (p % 5)
            0: palette = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            1: palette = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
            2: palette = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
            default: foreach (palette[c]) palette[c] = 16'($urandom);
         endcase
         case ((p + p / 8) % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 77;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 77;
            end
            default: begin
               send_idle_pct = 29;
               stall_pct <= 29;
            end
         endcase
         drain_colors();
         // Junk above the mode field must be dropped, and the spare index must change nothing.
         set_register(CSR_MODE, {13'($urandom), 3'(p)});
         for (int c = 0; c < 6; c++) set_register(3'(CSR_A_RED + c), palette[c]);
         set_register(CsrSpare, 16'($urandom));
         csr_if.valid <= 1'b0;
         settings_count++;
         repeat (PointsPerPhase)
            send_point(random_coord(), random_coord(), random_coord(), 1'b0, Black);
      end

      drain_colors();
      repeat (SettleCycles) @(posedge clock);
      $display("Run summary: %0d points shaded under %0d register settings, %0d colors checked,",
               points_sent, settings_count, colors_checked);
      $display("  all six patterns and both spare modes, with idle, stall and hold-off phases.");
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
